// ===== design/llx_pkg.sv =====
// ----------------------------------------------------------------------------
// llx_pkg: shared types and constants of the light-sensor lux linearizer
// Widths, calibration defaults, lux points, class thresholds and the
// request/response structs of the shared divider.
// ----------------------------------------------------------------------------
package llx_pkg;

   localparam int ADC_W              = 12;
   localparam int MV_W               = 12;
   localparam int LUX_W              = 15;
   localparam int CLASS_W            = 3;
   localparam int NUM_CAL            = 5;
   localparam int NUM_CLASS_THR      = 4;
   localparam int CSR_INDEX_W        = 3;
   localparam int SAMPLES_PER_RESULT = 32;
   localparam int QUEUE_DEPTH        = 2;

   // millivolt scaling: avg * MV_FULL_SCALE / ADC_FULL_SCALE
   localparam int MV_PROD_W          = 24;
   localparam logic [MV_W-1:0]  MV_FULL_SCALE  = 12'd3300;
   localparam logic [ADC_W-1:0] ADC_FULL_SCALE = 12'd4095;

   // shared divider: quotient always fits in DIV_QUO_W bits
   localparam int DIV_DIVIDEND_W = 27;
   localparam int DIV_DIVISOR_W  = 12;
   localparam int DIV_QUO_W      = 15;
   localparam int DIV_STEP_W     = 4;

   // calibration lux points and class thresholds, unsigned Q.4
   localparam logic [LUX_W-1:0] LUX_PT [NUM_CAL] =
      '{15'd4382, 15'd5578, 15'd8355, 15'd20683, 15'd29918};
   localparam logic [LUX_W-1:0] CLASS_THR [NUM_CLASS_THR] =
      '{15'd4980, 15'd6966, 15'd14519, 15'd25301};
   localparam logic [ADC_W-1:0] CAL_RESET [NUM_CAL] =
      '{12'd533, 12'd711, 12'd1648, 12'd3435, 12'd4095};

   typedef logic [NUM_CAL-1:0][ADC_W-1:0] cal_array_type;

   typedef struct packed {
      logic                      start;
      logic [DIV_DIVIDEND_W-1:0] dividend;
      logic [DIV_DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== design/llx_if.sv =====
// ----------------------------------------------------------------------------
// llx_if: sample and result channels of the lux linearizer
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface llx_req_if;
   logic                      valid;
   logic                      ready;
   logic [llx_pkg::ADC_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface llx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [llx_pkg::ADC_W-1:0]   avg_raw;
   logic [llx_pkg::MV_W-1:0]    millivolts;
   logic [llx_pkg::LUX_W-1:0]   lux_q4;
   logic [llx_pkg::CLASS_W-1:0] light_class;
   logic                        led_on;

   modport source (output valid, output avg_raw, output millivolts, output lux_q4,
                   output light_class, output led_on, input ready);
   modport sink   (input valid, input avg_raw, input millivolts, input lux_q4,
                   input light_class, input led_on, output ready);
endinterface

// ===== design/llx_queue.sv =====
// ----------------------------------------------------------------------------
// llx_queue: small FIFO between accumulator and calibrator
// Holds completed sample sums until the back end takes them.
// ----------------------------------------------------------------------------
module llx_queue #(
   parameter int WIDTH = 17,
   parameter int DEPTH = llx_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/llx_front.sv =====
// ----------------------------------------------------------------------------
// llx_front: sample accumulator
// Sums samples and pushes the sum of each complete group into the queue.
// ----------------------------------------------------------------------------
module llx_front #(
   parameter int SAMPLES_PER_RESULT = llx_pkg::SAMPLES_PER_RESULT,
   parameter int SUM_W = llx_pkg::ADC_W + $clog2(SAMPLES_PER_RESULT)
) (
   input  logic             clock,
   input  logic             reset,
   llx_req_if.sink          req_ch,
   input  logic             queue_full,
   output logic             push,
   output logic [SUM_W-1:0] push_sum
);

   localparam int CNT_W = (SAMPLES_PER_RESULT > 1) ? $clog2(SAMPLES_PER_RESULT) : 1;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             last;
   logic             accept;
   logic [SUM_W-1:0] sum_next;

   assign last     = (count_ff == CNT_W'(SAMPLES_PER_RESULT - 1));
   // stall only the transaction that closes a group while the queue is full
   assign req_ch.ready = !(last && queue_full);
   assign accept   = req_ch.valid && req_ch.ready;
   assign sum_next = sum_ff + SUM_W'(req_ch.sample);
   assign push     = accept && last;
   assign push_sum = sum_next;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/llx_div.sv =====
// ----------------------------------------------------------------------------
// llx_div: shared restoring divider
// One quotient bit per cycle; the quotient must fit in DIV_QUO_W bits.
// ----------------------------------------------------------------------------
module llx_div (
   input  logic                 clock,
   input  logic                 reset,
   input  llx_pkg::div_req_type req,
   output llx_pkg::div_rsp_type rsp
);

   localparam int DD_W = llx_pkg::DIV_DIVIDEND_W;
   localparam int Q_W  = llx_pkg::DIV_QUO_W;
   localparam int S_W  = llx_pkg::DIV_STEP_W;

   logic            busy_ff;
   logic            done_ff;
   logic [S_W-1:0]  step_ff;
   logic [DD_W-1:0] rem_ff;
   logic [DD_W-1:0] dsh_ff;
   logic [Q_W-1:0]  quo_ff;
   logic            fits;

   assign fits         = (rem_ff >= dsh_ff);
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= S_W'(Q_W - 1);
         end else if (busy_ff) begin
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.dividend;
         dsh_ff <= DD_W'(req.divisor) << (Q_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[Q_W-2:0], fits};
      end
   end

endmodule

// ===== design/llx_back.sv =====
// ----------------------------------------------------------------------------
// llx_back: calibration sequencer
// Turns one sample sum into average, millivolts, lux, class and LED flag.
// ----------------------------------------------------------------------------
module llx_back #(
   parameter int SAMPLES_PER_RESULT = llx_pkg::SAMPLES_PER_RESULT,
   parameter int SUM_W = llx_pkg::ADC_W + $clog2(SAMPLES_PER_RESULT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  llx_pkg::cal_array_type cal_points,
   input  logic                  queue_not_empty,
   input  logic [SUM_W-1:0]      queue_sum,
   output logic                  queue_pop,
   output llx_pkg::div_req_type  div_req,
   input  llx_pkg::div_rsp_type  div_rsp,
   llx_rsp_if.source             rsp_ch
);

   localparam int ADC_W   = llx_pkg::ADC_W;
   localparam int LUX_W   = llx_pkg::LUX_W;
   localparam int MV_W    = llx_pkg::MV_W;
   localparam int CLASS_W = llx_pkg::CLASS_W;
   localparam int NCAL    = llx_pkg::NUM_CAL;
   localparam int NTHR    = llx_pkg::NUM_CLASS_THR;
   localparam int PROD_W  = llx_pkg::DIV_DIVIDEND_W;
   localparam int MVP_W   = llx_pkg::MV_PROD_W;

   // average as sum * ceil(2^(SUM_W+L) / N) >> (SUM_W+L), L = clog2(N):
   // exact floor for every sum that fits SUM_W bits
   localparam int AVG_SHIFT  = SUM_W + $clog2(SAMPLES_PER_RESULT);
   localparam int RECIP_W    = SUM_W + 1;
   localparam int AVG_PROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_RESULT) - 64'd1) /
               64'(SAMPLES_PER_RESULT));

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SEG       = 6'b000010,
      ST_MUL       = 6'b000100,
      ST_LUX_START = 6'b001000,
      ST_LUX_WAIT  = 6'b010000,
      ST_OUT       = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [ADC_W-1:0]     avg_ff, avg_in;
   logic [MVP_W-1:0]     mv_prod_ff, mv_prod_in;
   logic [MV_W-1:0]      mv_ff, mv_in;
   logic                 led_ff, led_in;
   logic [LUX_W-1:0]     lux_ff, lux_in;
   logic                 use_div_ff, use_div_in;
   logic [ADC_W-1:0]     off_ff, off_in;
   logic [ADC_W-1:0]     span_ff, span_in;
   logic [LUX_W-1:0]     dl_ff, dl_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADC_W-1:0]     rsp_avg_ff;
   logic [MV_W-1:0]      rsp_mv_ff;
   logic [LUX_W-1:0]     rsp_lux_ff;
   logic [CLASS_W-1:0]   rsp_class_ff;
   logic                 rsp_led_ff;
   logic                 rsp_load;
   logic                 out_free;

   logic [AVG_PROD_W-1:0] avg_prod;

   // segment selection
   logic [NCAL-2:0]      seg_hit;
   logic                 seg_found;
   logic [ADC_W-1:0]     seg_lo;
   logic [ADC_W-1:0]     seg_hi;
   logic [LUX_W-1:0]     seg_llo;
   logic [LUX_W-1:0]     seg_lhi;

   // millivolt correction and classification
   logic [MV_W-1:0]      mv_q0;
   logic [ADC_W:0]       mv_rem;
   logic [CLASS_W-1:0]   light_class;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign avg_prod = queue_sum * AVG_RECIP;

   always_comb begin
      seg_found = 1'b0;
      seg_lo    = '0;
      seg_hi    = '0;
      seg_llo   = '0;
      seg_lhi   = '0;
      for (int i = 0; i < NCAL - 1; i++) begin
         seg_hit[i] = (avg_ff >= cal_points[i]) && (avg_ff <= cal_points[i+1]);
      end
      // first matching segment wins
      for (int i = NCAL - 2; i >= 0; i--) begin
         if (seg_hit[i]) begin
            seg_found = 1'b1;
            seg_lo    = cal_points[i];
            seg_hi    = cal_points[i+1];
            seg_llo   = llx_pkg::LUX_PT[i];
            seg_lhi   = llx_pkg::LUX_PT[i+1];
         end
      end
   end

   // x / 4095 as (x >> 12) plus one correction step
   assign mv_q0  = mv_prod_ff[MVP_W-1:ADC_W];
   assign mv_rem = {1'b0, mv_prod_ff[ADC_W-1:0]} + (ADC_W+1)'(mv_q0);

   always_comb begin
      light_class = CLASS_W'(NTHR);
      for (int k = NTHR - 1; k >= 0; k--) begin
         if (lux_ff <= llx_pkg::CLASS_THR[k]) begin
            light_class = CLASS_W'(k);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      avg_in      = avg_ff;
      mv_prod_in  = mv_prod_ff;
      mv_in       = mv_ff;
      led_in      = led_ff;
      lux_in      = lux_ff;
      use_div_in  = use_div_ff;
      off_in      = off_ff;
      span_in     = span_ff;
      dl_in       = dl_ff;
      prod_in     = prod_ff;
      queue_pop   = 1'b0;
      rsp_load    = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = span_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (queue_not_empty) begin
               queue_pop = 1'b1;
               avg_in    = avg_prod[AVG_SHIFT +: ADC_W];
               state_in  = ST_SEG;
            end
         end
         ST_SEG: begin
            mv_prod_in = MVP_W'(avg_ff * llx_pkg::MV_FULL_SCALE);
            led_in     = (avg_ff < cal_points[1]);
            use_div_in = 1'b0;
            off_in     = avg_ff - seg_lo;
            span_in    = seg_hi - seg_lo;
            dl_in      = seg_lhi - seg_llo;
            if (avg_ff <= cal_points[0]) begin
               lux_in = llx_pkg::LUX_PT[0];
            end else if (avg_ff >= cal_points[NCAL-1]) begin
               lux_in = llx_pkg::LUX_PT[NCAL-1];
            end else if (seg_found) begin
               lux_in     = seg_llo;
               use_div_in = (seg_hi != seg_lo);
            end else begin
               lux_in = '0;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(off_ff * dl_ff);
            mv_in    = (mv_rem >= (ADC_W+1)'(llx_pkg::ADC_FULL_SCALE)) ? mv_q0 + 1'b1 : mv_q0;
            state_in = use_div_ff ? ST_LUX_START : ST_OUT;
         end
         ST_LUX_START: begin
            div_req.start = 1'b1;
            state_in      = ST_LUX_WAIT;
         end
         ST_LUX_WAIT: begin
            if (div_rsp.done) begin
               lux_in   = lux_ff + div_rsp.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff     <= avg_in;
      mv_prod_ff <= mv_prod_in;
      mv_ff      <= mv_in;
      led_ff     <= led_in;
      lux_ff     <= lux_in;
      use_div_ff <= use_div_in;
      off_ff     <= off_in;
      span_ff    <= span_in;
      dl_ff      <= dl_in;
      prod_ff    <= prod_in;
      if (rsp_load) begin
         rsp_avg_ff   <= avg_ff;
         rsp_mv_ff    <= mv_ff;
         rsp_lux_ff   <= lux_ff;
         rsp_class_ff <= light_class;
         rsp_led_ff   <= led_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.avg_raw     = rsp_avg_ff;
   assign rsp_ch.millivolts  = rsp_mv_ff;
   assign rsp_ch.lux_q4      = rsp_lux_ff;
   assign rsp_ch.light_class = rsp_class_ff;
   assign rsp_ch.led_on      = rsp_led_ff;

endmodule

// ===== design/ldr_lux_linearizer_top.sv =====
// ----------------------------------------------------------------------------
// ldr_lux_linearizer_top: light-sensor averager and lux calibrator
//
// req_ch carries 12-bit converter samples, one transaction per sample. Every
// SAMPLES_PER_RESULT samples, rsp_ch delivers one result: truncated average,
// millivolts, lux in unsigned Q.4 interpolated over the five calibration
// points, a five-level light class and the LED flag.
// csr_we/csr_index/csr_wdata write calibration point csr_index (0..4);
// higher indexes are dropped. Write only while no group is in flight.
// Samples are taken one per cycle; a two-entry queue holds finished group
// sums. rsp_ch.valid rises after the closing sum passes the queue and the
// calibrator states IDLE, SEG, MUL, LUX_START, LUX_WAIT and OUT, of which
// the LUX states are skipped for a clamp, a zero-width segment or no
// segment. The 15-step lux divider makes the longer path; each result is
// done within a default group of 32 samples, so sampling runs without stalls
// while rsp_ch keeps up. Only the sample that closes a group waits, and only
// while the queue is full. While rsp_ch.ready is low, the finished result
// is held in the output register and the calibrator waits with the next
// one; sampling continues until the queue fills. Reset clears sum, count,
// queue and output valid and loads the default calibration points.
// ----------------------------------------------------------------------------
module ldr_lux_linearizer_top #(
   parameter int SAMPLES_PER_RESULT = llx_pkg::SAMPLES_PER_RESULT
) (
   input  logic                            clock,
   input  logic                            reset,
   llx_req_if.sink                         req_ch,
   llx_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [llx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [llx_pkg::ADC_W-1:0]       csr_wdata
);

   localparam int SUM_W = llx_pkg::ADC_W + $clog2(SAMPLES_PER_RESULT);

   llx_pkg::cal_array_type cal_ff;
   logic                   push;
   logic [SUM_W-1:0]       push_sum;
   logic                   queue_full;
   logic                   queue_pop;
   logic                   queue_not_empty;
   logic [SUM_W-1:0]       queue_sum;
   llx_pkg::div_req_type   div_req;
   llx_pkg::div_rsp_type   div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < llx_pkg::NUM_CAL; i++) begin
            cal_ff[i] <= llx_pkg::CAL_RESET[i];
         end
      end else if (csr_we) begin
         for (int i = 0; i < llx_pkg::NUM_CAL; i++) begin
            if (csr_index == llx_pkg::CSR_INDEX_W'(i)) begin
               cal_ff[i] <= csr_wdata;
            end
         end
      end
   end

   llx_front #(
      .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
      .SUM_W              (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_sum   (push_sum)
   );

   llx_queue #(
      .WIDTH (SUM_W),
      .DEPTH (llx_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_sum),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_sum)
   );

   llx_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   llx_back #(
      .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
      .SUM_W              (SUM_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cal_points      (cal_ff),
      .queue_not_empty (queue_not_empty),
      .queue_sum       (queue_sum),
      .queue_pop       (queue_pop),
      .div_req         (div_req),
      .div_rsp         (div_rsp),
      .rsp_ch          (rsp_ch)
   );

endmodule
